// ===== rtl/bmpp_pkg.sv =====
// bmpp_pkg: shared types and constants of the bmp header and pixel parser
// used by bmpp_parse and bmp_header_pixel_parser_core; depends on nothing
`default_nettype none

package bmpp_pkg;

  localparam int HEADER_BYTES = 54;
  localparam int WIDTH_POS    = 18;
  localparam int HEIGHT_POS   = 22;
  localparam int DIM_SHOWN_W  = 13;
  localparam int INDEX_W      = 12;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic                   kind;
    logic [DIM_SHOWN_W-1:0] image_width;
    logic [DIM_SHOWN_W-1:0] image_height;
    logic                   size_error;
    logic [INDEX_W-1:0]     column_index;
    logic [INDEX_W-1:0]     row_index;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic                   last_pixel;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bmp_header_pixel_parser_core.sv =====
// bmp_header_pixel_parser_core: top level, byte channel in, result channel out
// depends on bmpp_pkg and bmpp_parse; holds the result register and a skid stage
//
//   channel   direction  handshake                   payload
//   byte      in         byte_valid / byte_stall     data_byte, frame_start
//   result    out        result_valid / result_stall kind, image_width, image_height,
//                                                    size_error, column_index, row_index,
//                                                    red, green, blue, last_pixel
//
// one byte is taken per cycle while byte_stall is low; a result is registered into the
// result register from the byte that completes it (header byte 53, third byte of a
// triplet), or into the skid stage while the result register is stalled;
// byte_stall rises only while the skid stage is full
// rst is synchronous and restarts the parser in the header phase with both stages empty
`default_nettype none

module bmp_header_pixel_parser_core #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_start,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             kind,
  output logic [12:0]      image_width,
  output logic [12:0]      image_height,
  output logic             size_error,
  output logic [11:0]      column_index,
  output logic [11:0]      row_index,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic             last_pixel
);

  logic               accept;
  logic               res_valid;
  bmpp_pkg::result_t  res;
  logic               out_take;

  logic               out_valid;
  bmpp_pkg::result_t  out_data;
  logic               skid_valid;
  bmpp_pkg::result_t  skid_data;

  assign byte_stall = skid_valid;
  assign accept     = byte_valid && !skid_valid;
  assign out_take   = out_valid && !result_stall;

  bmpp_parse #(
    .MAX_DIM (MAX_DIM)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // payload registers follow the same transfer decisions as the valid bits
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (res_valid) begin
      if (!out_valid || out_take) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  assign result_valid = out_valid;
  assign kind         = out_data.kind;
  assign image_width  = out_data.image_width;
  assign image_height = out_data.image_height;
  assign size_error   = out_data.size_error;
  assign column_index = out_data.column_index;
  assign row_index    = out_data.row_index;
  assign red          = out_data.red;
  assign green        = out_data.green;
  assign blue         = out_data.blue;
  assign last_pixel   = out_data.last_pixel;

endmodule

`default_nettype wire

// ===== rtl/bmpp_parse.sv =====
// bmpp_parse: header byte counter, size capture and pixel triplet assembly
// depends on bmpp_pkg; one transfer updates the state, results leave combinationally
`default_nettype none

module bmpp_parse #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            frame_start,
  output logic                 res_valid,
  output bmpp_pkg::result_t    res
);

  localparam int          COUNT_W = $clog2(MAX_DIM + 1);
  localparam logic [31:0] MAX_W   = 32'(MAX_DIM);

  logic [5:0]         header_count, header_count_next;
  logic [31:0]        width_word, width_word_next;
  logic [31:0]        height_word, height_word_next;
  logic [COUNT_W-1:0] outer_count, outer_count_next;
  logic [COUNT_W-1:0] inner_count, inner_count_next;
  logic [1:0]         triplet_phase, triplet_phase_next;
  logic [7:0]         held_blue, held_blue_next;
  logic [7:0]         held_green, held_green_next;
  bmpp_pkg::phase_t   parse_phase, parse_phase_next;

  // a frame start byte is header byte 0 of a fresh file
  logic [5:0]         cur_count;
  logic [31:0]        cur_w, cur_h, cap_w, cap_h;
  logic [1:0]         cur_trip;
  bmpp_pkg::phase_t   cur_phase;
  logic               hdr_last, size_err, size_empty, last_row, last_col;

  function automatic logic [bmpp_pkg::DIM_SHOWN_W-1:0] shown_dim(input logic [31:0] w);
    logic [31:0] s;
    begin
      if (w[31]) begin
        s = '0;
      end else if (w > MAX_W) begin
        s = MAX_W;
      end else begin
        s = w;
      end
      return s[bmpp_pkg::DIM_SHOWN_W-1:0];
    end
  endfunction

  always_comb begin
    cur_count = frame_start ? '0 : header_count;
    cur_w     = frame_start ? '0 : width_word;
    cur_h     = frame_start ? '0 : height_word;
    cur_trip  = frame_start ? '0 : triplet_phase;
    cur_phase = frame_start ? bmpp_pkg::PH_HEADER : parse_phase;
  end

  // little-endian capture of the signed width and height words
  always_comb begin
    cap_w = cur_w;
    cap_h = cur_h;
    case (cur_count)
      6'(bmpp_pkg::WIDTH_POS):      cap_w[7:0]   = data_byte;
      6'(bmpp_pkg::WIDTH_POS + 1):  cap_w[15:8]  = data_byte;
      6'(bmpp_pkg::WIDTH_POS + 2):  cap_w[23:16] = data_byte;
      6'(bmpp_pkg::WIDTH_POS + 3):  cap_w[31:24] = data_byte;
      6'(bmpp_pkg::HEIGHT_POS):     cap_h[7:0]   = data_byte;
      6'(bmpp_pkg::HEIGHT_POS + 1): cap_h[15:8]  = data_byte;
      6'(bmpp_pkg::HEIGHT_POS + 2): cap_h[23:16] = data_byte;
      6'(bmpp_pkg::HEIGHT_POS + 3): cap_h[31:24] = data_byte;
      default: ;
    endcase
  end

  always_comb begin
    hdr_last   = (cur_count == 6'(bmpp_pkg::HEADER_BYTES - 1));
    size_err   = (!cap_w[31] && (cap_w > MAX_W)) || (!cap_h[31] && (cap_h > MAX_W));
    size_empty = cap_w[31] || cap_h[31] || (cap_w == '0) || (cap_h == '0);
    // in the pixel phase both sizes lie in 1..MAX_DIM and fit the counters
    last_row   = ((inner_count + COUNT_W'(1)) == cur_h[COUNT_W-1:0]);
    last_col   = ((outer_count + COUNT_W'(1)) == cur_w[COUNT_W-1:0]);
  end

  always_comb begin
    header_count_next  = cur_count;
    width_word_next    = cur_w;
    height_word_next   = cur_h;
    outer_count_next   = outer_count;
    inner_count_next   = inner_count;
    triplet_phase_next = cur_trip;
    held_blue_next     = held_blue;
    held_green_next    = held_green;
    parse_phase_next   = cur_phase;
    case (cur_phase)
      bmpp_pkg::PH_HEADER: begin
        header_count_next = cur_count + 6'd1;
        width_word_next   = cap_w;
        height_word_next  = cap_h;
        if (hdr_last) begin
          parse_phase_next   = (size_err || size_empty) ? bmpp_pkg::PH_DONE
                                                        : bmpp_pkg::PH_PIXELS;
          outer_count_next   = '0;
          inner_count_next   = '0;
          triplet_phase_next = '0;
        end
      end
      bmpp_pkg::PH_PIXELS: begin
        if (cur_trip == 2'd0) begin
          held_blue_next     = data_byte;
          triplet_phase_next = 2'd1;
        end else if (cur_trip == 2'd1) begin
          held_green_next    = data_byte;
          triplet_phase_next = 2'd2;
        end else begin
          triplet_phase_next = 2'd0;
          if (last_row) begin
            inner_count_next = '0;
            if (last_col) begin
              outer_count_next = '0;
              parse_phase_next = bmpp_pkg::PH_DONE;
            end else begin
              outer_count_next = outer_count + COUNT_W'(1);
            end
          end else begin
            inner_count_next = inner_count + COUNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_valid        = 1'b0;
    res              = '0;
    res.image_width  = shown_dim(cap_w);
    res.image_height = shown_dim(cap_h);
    case (cur_phase)
      bmpp_pkg::PH_HEADER: begin
        res_valid      = accept && hdr_last;
        res.kind       = bmpp_pkg::KIND_HEADER;
        res.size_error = size_err;
      end
      bmpp_pkg::PH_PIXELS: begin
        res_valid        = accept && (cur_trip != 2'd0) && (cur_trip != 2'd1);
        res.kind         = bmpp_pkg::KIND_PIXEL;
        res.column_index = bmpp_pkg::INDEX_W'(outer_count);
        res.row_index    = bmpp_pkg::INDEX_W'(inner_count);
        res.red          = data_byte;
        res.green        = held_green;
        res.blue         = held_blue;
        res.last_pixel   = last_row && last_col;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count  <= '0;
      width_word    <= '0;
      height_word   <= '0;
      outer_count   <= '0;
      inner_count   <= '0;
      triplet_phase <= '0;
      held_blue     <= '0;
      held_green    <= '0;
      parse_phase   <= bmpp_pkg::PH_HEADER;
    end else if (accept) begin
      header_count  <= header_count_next;
      width_word    <= width_word_next;
      height_word   <= height_word_next;
      outer_count   <= outer_count_next;
      inner_count   <= inner_count_next;
      triplet_phase <= triplet_phase_next;
      held_blue     <= held_blue_next;
      held_green    <= held_green_next;
      parse_phase   <= parse_phase_next;
    end
  end

endmodule

`default_nettype wire
